FILE: src/xor_sprite_framebuffer_unit_defines.svh
// Assertion macros shared by the xor sprite framebuffer RTL.
`ifndef XOR_SPRITE_FRAMEBUFFER_UNIT_DEFINES_SVH
`define XOR_SPRITE_FRAMEBUFFER_UNIT_DEFINES_SVH

// Check that a condition implies a property in the same cycle.
`define XSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xsf assertion failed");

// Check that a condition implies a property from the next cycle on.
`define XSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xsf assertion failed");

`endif

FILE: src/xsf_pkg.sv
// Package with types and constants of the xor sprite framebuffer.
package xsf_pkg;

	// Default screen size
	localparam int DEF_SCREEN_WIDTH  = 64;
	localparam int DEF_SCREEN_HEIGHT = 32;

	// Number of pixels in one sprite row
	localparam int SPRITE_W = 8;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_BEGIN = 2'd1,
		OP_DRAW  = 2'd2,
		OP_READ  = 2'd3
	} xsf_op_t;

	typedef struct packed {
		xsf_op_t     op;
		logic [7:0]  x_pos;
		logic [7:0]  y_pos;
		logic [7:0]  row_index;
		logic [7:0]  row_bits;
	} xsf_req_t;

	typedef struct packed {
		logic pixel;
		logic collision;
	} xsf_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_UPDATE
	} xsf_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic fetch;
		logic update;
	} xsf_cmd_t;

endpackage

FILE: src/xsf_ctrl.sv
// Controller state machine of the xor sprite framebuffer.
module xsf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output xsf_pkg::xsf_cmd_t  cmd
);
	import xsf_pkg::*;

	xsf_state_t state_q;
	xsf_state_t state_next;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Advance: fetch the row, then update it and post the result
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_FETCH;
				end
			end
			ST_FETCH:  state_next = ST_UPDATE;
			ST_UPDATE: state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	// Drive datapath commands
	always_comb begin
		busy       = 1'b1;
		cmd.load   = 1'b0;
		cmd.fetch  = 1'b0;
		cmd.update = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_FETCH:  cmd.fetch = 1'b1;
			ST_UPDATE: cmd.update = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

endmodule

FILE: src/xsf_datapath.sv
// Datapath of the xor sprite framebuffer: row memory, sprite XOR and flag.
module xsf_datapath #(
	parameter int SCREEN_WIDTH  = xsf_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = xsf_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  xsf_pkg::xsf_cmd_t  cmd,
	input  xsf_pkg::xsf_req_t  request,
	output xsf_pkg::xsf_rsp_t  result,
	output logic               done
);
	import xsf_pkg::*;

	localparam int         COL_W     = $clog2(SCREEN_WIDTH);
	localparam int         ROW_W     = $clog2(SCREEN_HEIGHT);
	localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);
	localparam logic [8:0] HEIGHT_LIM = 9'(SCREEN_HEIGHT);

	xsf_req_t                 item_q;
	logic [SCREEN_WIDTH-1:0]  mem [SCREEN_HEIGHT];
	logic [SCREEN_HEIGHT-1:0] row_valid_q;
	logic [SCREEN_WIDTH-1:0]  rd_data_s1;
	logic                     valid_s1;
	logic                     row_ok_s1;
	logic [ROW_W-1:0]         row_idx_s1;
	logic                     flag_q;
	xsf_rsp_t                 result_q;
	logic                     done_q;

	logic [7:0]               tgt_row;
	logic                     row_ok;
	logic [ROW_W-1:0]         row_idx;
	logic [SCREEN_WIDTH-1:0]  row_data;
	logic [SCREEN_WIDTH-1:0]  mask;
	logic [SCREEN_WIDTH-1:0]  new_row;
	logic                     hit;
	logic                     flag_next;
	logic                     pix;
	logic                     wr_en;

	// Latch the item on accept
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= request;
		end
	end

	// Pick the target row: draw adds the row index, read uses y directly
	always_comb begin
		if (item_q.op == OP_DRAW) begin
			tgt_row = item_q.y_pos + item_q.row_index;
		end else begin
			tgt_row = item_q.y_pos;
		end
		row_ok  = {1'b0, tgt_row} < HEIGHT_LIM;
		row_idx = tgt_row[ROW_W-1:0];
	end

	// Read the row from memory
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			rd_data_s1 <= mem[row_idx];
			row_idx_s1 <= row_idx;
			row_ok_s1  <= row_ok;
			valid_s1   <= row_ok && row_valid_q[row_idx];
		end
	end

	// Rows never written since reset or clear read as blank
	assign row_data = valid_s1 ? rd_data_s1 : '0;

	// Build the column mask of lit sprite pixels, dropping off-screen ones
	always_comb begin
		logic [7:0] col;
		mask = '0;
		for (int j = 0; j < SPRITE_W; j++) begin
			col = item_q.x_pos + 8'(j);
			if (({1'b0, col} < WIDTH_LIM) && item_q.row_bits[SPRITE_W-1-j]) begin
				mask[col[COL_W-1:0]] = 1'b1;
			end
		end
	end

	// XOR the sprite row and detect erased pixels
	assign new_row = row_data ^ mask;
	assign hit     = |(row_data & mask);
	assign wr_en   = cmd.update && (item_q.op == OP_DRAW) && row_ok_s1;

	// Next flag value per op
	always_comb begin
		case (item_q.op)
			OP_BEGIN: flag_next = 1'b0;
			OP_DRAW:  flag_next = flag_q | (row_ok_s1 & hit);
			default:  flag_next = flag_q;
		endcase
	end

	// Read one pixel, zero when off screen
	assign pix = (item_q.op == OP_READ) && row_ok_s1 &&
		({1'b0, item_q.x_pos} < WIDTH_LIM) && row_data[item_q.x_pos[COL_W-1:0]];

	// Write back the updated row
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[row_idx_s1] <= new_row;
		end
	end

	// Track which rows hold data; clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (cmd.update && (item_q.op == OP_CLEAR)) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[row_idx_s1] <= 1'b1;
		end
	end

	// Update flag and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cmd.update) begin
				flag_q <= flag_next;
			end
		end
	end

	// Register the result
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q.pixel     <= pix;
			result_q.collision <= flag_next;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

FILE: src/xor_sprite_framebuffer_unit.sv
// Top level of the xor sprite framebuffer: controller plus datapath.
//
// Usage: drive request and raise start; the item is taken at a rising edge
// where start is high and busy is low. Ops: clear screen, begin sprite
// (clears the collision flag), draw one 8-pixel sprite row by XOR, and
// read one pixel.
// Each item returns one result on result, marked by done for a single
// cycle. done rises after the fetch and update steps, and the result is
// taken at the rising edge that ends the done cycle; the receiver
// cannot stall and must take the result in that cycle.
// The block takes no new item while busy. The controller takes the item
// in its idle state, reads the framebuffer row in its fetch state, then
// XORs it and writes it back in its update state. The next item can be
// taken at the edge that ends the done cycle.
// Reset: asynchronous, active low. It blanks the screen at once through
// per-row valid bits, clears the collision flag and idles the controller.
// Clear screen also works through the valid bits and passes through the
// same fetch and update states as any other item.
`include "xor_sprite_framebuffer_unit_defines.svh"

module xor_sprite_framebuffer_unit #(
	parameter int SCREEN_WIDTH  = xsf_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = xsf_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  xsf_pkg::xsf_req_t  request,
	output xsf_pkg::xsf_rsp_t  result,
	output logic               done
);
	import xsf_pkg::*;

	xsf_cmd_t cmd;

	xsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	xsf_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result),
		.done    (done)
	);

	// Accepted item goes busy, and its result follows after fetch and update
	`XSF_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`XSF_ASSERT_IMPL(a_accept_done, clk, arst_n, start && !busy, ##3 done)
	// Result strobe lasts one cycle and comes with the block idle
	`XSF_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`XSF_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)

endmodule
